// ===== hdl/arp_pkg.sv =====
// ----------------------------------------------------------------------------
// arp_pkg
// Shared types and codes for the note arpeggiator.
// ----------------------------------------------------------------------------
package arp_pkg;

   typedef struct packed {
      logic [6:0] vel;
      logic [6:0] pitch;
   } arp_entry_type;

   localparam logic [2:0] CMD_PRESS   = 3'd0;
   localparam logic [2:0] CMD_RELEASE = 3'd1;
   localparam logic [2:0] CMD_STEP    = 3'd2;
   localparam logic [2:0] CMD_GATE    = 3'd3;
   localparam logic [2:0] CMD_RESTART = 3'd4;

   localparam logic [2:0] MODE_UP     = 3'd0;
   localparam logic [2:0] MODE_DOWN   = 3'd1;
   localparam logic [2:0] MODE_UPDOWN = 3'd2;
   localparam logic [2:0] MODE_PLAYED = 3'd3;
   localparam logic [2:0] MODE_RANDOM = 3'd4;

   localparam logic EV_ON  = 1'b0;
   localparam logic EV_OFF = 1'b1;

   localparam logic CSR_MODE = 1'b0;
   localparam logic CSR_SPAN = 1'b1;

   localparam logic [2:0] SPAN_MIN = 3'd1;
   localparam logic [2:0] SPAN_MAX = 3'd4;

endpackage

// ===== hdl/arp_ram.sv =====
// ----------------------------------------------------------------------------
// arp_ram
// Single-port-write, registered-read note table.
// ----------------------------------------------------------------------------
module arp_ram #(
   parameter int DEPTH = 32,
   parameter int DW    = 14
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [DW-1:0]            wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [DW-1:0]            rdata
);

   logic [DW-1:0] mem_ff [DEPTH];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/arp_div.sv =====
// ----------------------------------------------------------------------------
// arp_div
// Restoring divider, one quotient bit per cycle, 32-bit dividend.
// ----------------------------------------------------------------------------
module arp_div #(
   parameter int DW = 9
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [31:0]   dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [31:0]   quot,
   output logic [DW-1:0] rem
);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [4:0]    cnt_ff, cnt_in;
   logic [31:0]   quo_ff, quo_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] dsr_ff, dsr_in;
   logic [DW:0]   trial;
   logic [DW:0]   diff;
   logic          ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[31]};
      diff    = trial - {1'b0, dsr_ff};
      ge      = (trial >= {1'b0, dsr_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[30:0], ge};
         rem_in = ge ? diff[DW-1:0] : trial[DW-1:0];
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;
   assign rem  = rem_ff;

endmodule

// ===== hdl/note_arpeggiator.sv =====
// ----------------------------------------------------------------------------
// note_arpeggiator
// Arpeggiator: held-note tables in RAM, step pattern by mode and octave span.
// ----------------------------------------------------------------------------
// Takes one command transfer at a time. Held notes live in two RAMs (press
// order and pitch sorted); table updates walk them one entry at a time
// through the registered read, and a full table drops its oldest note to
// take a new press. A step tick runs two passes of a shared divider. Gate
// end and restart send a note off for a sounding note. A finished event
// waits in the output register while the next command is taken.
module note_arpeggiator #(
   parameter int MAX_HELD = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // pitch[6:0], velocity[13:7], random_value[29:14]
   input  logic [2:0]  req_tuser,  // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // note_pitch[6:0], note_velocity[13:7]
   output logic        rsp_tuser,  // event_kind
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [2:0]  csr_wdata
);
   import arp_pkg::*;

   localparam int AW = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;
   localparam int HW = $clog2(MAX_HELD + 1);
   localparam int LW = HW + 2;
   localparam int DW = HW + 3;
   localparam int EW = $bits(arp_entry_type);

   typedef enum logic [25:0] {
      ST_IDLE     = 26'h0000001,
      ST_SRCH_RD  = 26'h0000002,
      ST_SRCH_EX  = 26'h0000004,
      ST_SH_RD    = 26'h0000008,
      ST_SH_EX    = 26'h0000010,
      ST_PFOUND   = 26'h0000020,
      ST_VELDONE  = 26'h0000040,
      ST_DROP1    = 26'h0000080,
      ST_DROP2    = 26'h0000100,
      ST_DROP3    = 26'h0000200,
      ST_APPEND   = 26'h0000400,
      ST_INS_RD   = 26'h0000800,
      ST_INS_EX   = 26'h0001000,
      ST_INS_DONE = 26'h0002000,
      ST_REL1     = 26'h0004000,
      ST_REL2     = 26'h0008000,
      ST_REL3     = 26'h0010000,
      ST_REL4     = 26'h0020000,
      ST_REL_END  = 26'h0040000,
      ST_OFF      = 26'h0080000,
      ST_STEP0    = 26'h0100000,
      ST_STEP1    = 26'h0200000,
      ST_DIV1     = 26'h0400000,
      ST_DIV2     = 26'h0800000,
      ST_NOTE     = 26'h1000000,
      ST_ON       = 26'h2000000
   } state_type;

   state_type     state_ff, state_in;
   state_type     ret_ff, ret_in;
   logic          sel_ff, sel_in;
   logic [6:0]    key_ff, key_in;
   logic          found_ff, found_in;
   logic [HW-1:0] idx_ff, idx_in;
   logic [6:0]    drop_ff, drop_in;
   logic [6:0]    pitch_ff, pitch_in;
   logic [6:0]    vel_ff, vel_in;
   logic [15:0]   rnd_ff, rnd_in;
   logic [HW-1:0] held_ff, held_in;
   logic [31:0]   pos_ff, pos_in;
   logic          snd_ff, snd_in;
   logic [6:0]    sndp_ff, sndp_in;
   logic [2:0]    mode_ff, mode_in;
   logic [2:0]    span_ff, span_in;
   logic [LW-1:0] len_ff, len_in;
   logic [1:0]    oct_ff, oct_in;
   logic [6:0]    notep_ff, notep_in;
   logic [6:0]    notev_ff, notev_in;
   logic          ov_ff, ov_in;
   logic          okind_ff, okind_in;
   logic [6:0]    opitch_ff, opitch_in;
   logic [6:0]    ovel_ff, ovel_in;
   logic          olast_ff, olast_in;

   logic          p_we, s_we;
   logic [AW-1:0] p_waddr, s_waddr, raddr;
   arp_entry_type p_wdata, s_wdata, p_rd, s_rd, rd, note_e, new_e;
   logic [EW-1:0] p_rdata, s_rdata;

   logic          div_start, div_done;
   logic [31:0]   div_dividend, div_quot;
   logic [DW-1:0] div_divisor, div_rem;

   logic [2:0]    m;
   logic [2:0]    oc;
   logic          updown;
   logic [DW-1:0] period;
   logic [DW-1:0] kval;
   logic [HW-1:0] ins_addr;
   logic [HW-1:0] slot;
   logic [HW-1:0] note_addr;
   logic [7:0]    psum;
   logic          out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign out_free   = !ov_ff || rsp_tready;
   assign p_rd       = p_rdata;
   assign s_rd       = s_rdata;
   assign rd         = sel_ff ? s_rd : p_rd;
   assign new_e      = '{vel: vel_ff, pitch: pitch_ff};

   always_comb begin
      m  = (mode_ff > MODE_RANDOM) ? MODE_RANDOM : mode_ff;
      oc = (span_ff < SPAN_MIN) ? SPAN_MIN : ((span_ff > SPAN_MAX) ? SPAN_MAX : span_ff);
      updown    = (m == MODE_UPDOWN) && (len_ff > LW'(1));
      period    = DW'({len_ff, 1'b0}) - DW'(2);
      kval      = (updown && (div_rem >= DW'(len_ff))) ? (period - div_rem) : div_rem;
      ins_addr  = idx_ff - HW'(1);
      slot      = div_rem[HW-1:0];
      note_addr = (m == MODE_DOWN) ? (held_ff - HW'(1) - slot) : slot;
      note_e    = ((m == MODE_PLAYED) || (m == MODE_RANDOM)) ? p_rd : s_rd;
      psum      = {1'b0, note_e.pitch} + 8'(4'd12 * oct_ff);
   end

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      sel_in    = sel_ff;
      key_in    = key_ff;
      found_in  = found_ff;
      idx_in    = idx_ff;
      drop_in   = drop_ff;
      pitch_in  = pitch_ff;
      vel_in    = vel_ff;
      rnd_in    = rnd_ff;
      held_in   = held_ff;
      pos_in    = pos_ff;
      snd_in    = snd_ff;
      sndp_in   = sndp_ff;
      mode_in   = mode_ff;
      span_in   = span_ff;
      len_in    = len_ff;
      oct_in    = oct_ff;
      notep_in  = notep_ff;
      notev_in  = notev_ff;
      ov_in     = ov_ff && !rsp_tready;
      okind_in  = okind_ff;
      opitch_in = opitch_ff;
      ovel_in   = ovel_ff;
      olast_in  = olast_ff;
      p_we      = 1'b0;
      s_we      = 1'b0;
      p_waddr   = idx_ff[AW-1:0];
      s_waddr   = idx_ff[AW-1:0];
      p_wdata   = new_e;
      s_wdata   = new_e;
      raddr     = idx_ff[AW-1:0];
      div_start    = 1'b0;
      div_dividend = pos_ff;
      div_divisor  = DW'(len_ff);

      if (csr_we) begin
         case (csr_addr)
            CSR_MODE: mode_in = csr_wdata;
            CSR_SPAN: span_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               pitch_in = req_tdata[6:0];
               vel_in   = req_tdata[13:7];
               rnd_in   = req_tdata[29:14];
               key_in   = req_tdata[6:0];
               idx_in   = '0;
               sel_in   = 1'b0;
               case (req_tuser)
                  CMD_PRESS: begin
                     ret_in   = ST_PFOUND;
                     state_in = ST_SRCH_RD;
                  end
                  CMD_RELEASE: begin
                     ret_in   = ST_REL1;
                     state_in = ST_SRCH_RD;
                  end
                  CMD_STEP:    state_in = ST_STEP0;
                  CMD_GATE:    state_in = ST_OFF;
                  CMD_RESTART: state_in = ST_OFF;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_SRCH_RD: begin
            if (idx_ff == held_ff) begin
               found_in = 1'b0;
               state_in = ret_ff;
            end else begin
               state_in = ST_SRCH_EX;
            end
         end
         ST_SRCH_EX: begin
            if ((idx_ff == '0) && !sel_ff) begin
               drop_in = rd.pitch;
            end
            if (rd.pitch == key_ff) begin
               found_in = 1'b1;
               state_in = ret_ff;
            end else begin
               idx_in   = idx_ff + HW'(1);
               state_in = ST_SRCH_RD;
            end
         end
         ST_SH_RD: begin
            state_in = (idx_ff == held_ff) ? ret_ff : ST_SH_EX;
         end
         ST_SH_EX: begin
            p_we     = !sel_ff;
            s_we     = sel_ff;
            p_waddr  = ins_addr[AW-1:0];
            s_waddr  = ins_addr[AW-1:0];
            p_wdata  = rd;
            s_wdata  = rd;
            idx_in   = idx_ff + HW'(1);
            state_in = ST_SH_RD;
         end
         ST_PFOUND: begin
            if (found_ff) begin
               p_we     = 1'b1;
               sel_in   = 1'b1;
               idx_in   = '0;
               ret_in   = ST_VELDONE;
               state_in = ST_SRCH_RD;
            end else if (held_ff == HW'(MAX_HELD)) begin
               idx_in   = HW'(1);
               ret_in   = ST_DROP1;
               state_in = ST_SH_RD;
            end else begin
               state_in = ST_APPEND;
            end
         end
         ST_VELDONE: begin
            s_we     = 1'b1;
            state_in = ST_IDLE;
         end
         ST_DROP1: begin
            sel_in   = 1'b1;
            key_in   = drop_ff;
            idx_in   = '0;
            ret_in   = ST_DROP2;
            state_in = ST_SRCH_RD;
         end
         ST_DROP2: begin
            idx_in   = idx_ff + HW'(1);
            ret_in   = ST_DROP3;
            state_in = ST_SH_RD;
         end
         ST_DROP3: begin
            held_in  = held_ff - HW'(1);
            state_in = ST_APPEND;
         end
         ST_APPEND: begin
            p_we     = 1'b1;
            p_waddr  = held_ff[AW-1:0];
            idx_in   = held_ff;
            state_in = ST_INS_RD;
         end
         ST_INS_RD: begin
            raddr = ins_addr[AW-1:0];
            if (idx_ff == '0) begin
               s_we     = 1'b1;
               state_in = ST_INS_DONE;
            end else begin
               state_in = ST_INS_EX;
            end
         end
         ST_INS_EX: begin
            s_we = 1'b1;
            if (s_rd.pitch > pitch_ff) begin
               s_wdata  = s_rd;
               idx_in   = idx_ff - HW'(1);
               state_in = ST_INS_RD;
            end else begin
               state_in = ST_INS_DONE;
            end
         end
         ST_INS_DONE: begin
            held_in  = held_ff + HW'(1);
            state_in = ST_IDLE;
         end
         ST_REL1: begin
            if (found_ff) begin
               idx_in   = idx_ff + HW'(1);
               ret_in   = ST_REL2;
               state_in = ST_SH_RD;
            end else begin
               state_in = ST_REL_END;
            end
         end
         ST_REL2: begin
            sel_in   = 1'b1;
            idx_in   = '0;
            ret_in   = ST_REL3;
            state_in = ST_SRCH_RD;
         end
         ST_REL3: begin
            idx_in   = idx_ff + HW'(1);
            ret_in   = ST_REL4;
            state_in = ST_SH_RD;
         end
         ST_REL4: begin
            held_in  = held_ff - HW'(1);
            state_in = ST_REL_END;
         end
         ST_REL_END: begin
            if (held_ff == '0) begin
               pos_in   = '0;
               state_in = ST_OFF;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OFF: begin
            if (!snd_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               ov_in     = 1'b1;
               okind_in  = EV_OFF;
               opitch_in = sndp_ff;
               ovel_in   = '0;
               olast_in  = 1'b1;
               snd_in    = 1'b0;
               state_in  = ST_IDLE;
            end
         end
         ST_STEP0: begin
            if (!snd_ff || out_free) begin
               if (snd_ff) begin
                  ov_in     = 1'b1;
                  okind_in  = EV_OFF;
                  opitch_in = sndp_ff;
                  ovel_in   = '0;
                  olast_in  = (held_ff == '0);
               end
               snd_in = 1'b0;
               if (held_ff == '0) begin
                  pos_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  len_in   = LW'(held_ff * oc);
                  state_in = ST_STEP1;
               end
            end
         end
         ST_STEP1: begin
            div_start    = 1'b1;
            div_dividend = (m == MODE_RANDOM) ? {16'd0, rnd_ff} : pos_ff;
            div_divisor  = updown ? period : DW'(len_ff);
            state_in     = ST_DIV1;
         end
         ST_DIV1: begin
            if (div_done) begin
               div_start    = 1'b1;
               div_dividend = 32'(kval);
               div_divisor  = DW'(held_ff);
               pos_in       = pos_ff + 32'd1;
               state_in     = ST_DIV2;
            end
         end
         ST_DIV2: begin
            raddr = note_addr[AW-1:0];
            if (div_done) begin
               oct_in   = div_quot[1:0];
               state_in = ST_NOTE;
            end
         end
         ST_NOTE: begin
            notep_in = (psum > 8'd127) ? 7'd127 : psum[6:0];
            notev_in = note_e.vel;
            state_in = ST_ON;
         end
         ST_ON: begin
            if (out_free) begin
               ov_in     = 1'b1;
               okind_in  = EV_ON;
               opitch_in = notep_ff;
               ovel_in   = notev_ff;
               olast_in  = 1'b1;
               snd_in    = 1'b1;
               sndp_in   = notep_ff;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
         held_ff  <= '0;
         pos_ff   <= '0;
         snd_ff   <= 1'b0;
         sndp_ff  <= '0;
         mode_ff  <= MODE_UP;
         span_ff  <= SPAN_MIN;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         held_ff  <= held_in;
         pos_ff   <= pos_in;
         snd_ff   <= snd_in;
         sndp_ff  <= sndp_in;
         mode_ff  <= mode_in;
         span_ff  <= span_in;
         ov_ff    <= ov_in;
      end
      sel_ff    <= sel_in;
      key_ff    <= key_in;
      found_ff  <= found_in;
      idx_ff    <= idx_in;
      drop_ff   <= drop_in;
      pitch_ff  <= pitch_in;
      vel_ff    <= vel_in;
      rnd_ff    <= rnd_in;
      len_ff    <= len_in;
      oct_ff    <= oct_in;
      notep_ff  <= notep_in;
      notev_ff  <= notev_in;
      okind_ff  <= okind_in;
      opitch_ff <= opitch_in;
      ovel_ff   <= ovel_in;
      olast_ff  <= olast_in;
   end

   arp_ram #(.DEPTH(MAX_HELD), .DW(EW)) u_press (
      .clock (clock),
      .we    (p_we),
      .waddr (p_waddr),
      .wdata (p_wdata),
      .raddr (raddr),
      .rdata (p_rdata)
   );

   arp_ram #(.DEPTH(MAX_HELD), .DW(EW)) u_sorted (
      .clock (clock),
      .we    (s_we),
      .waddr (s_waddr),
      .wdata (s_wdata),
      .raddr (raddr),
      .rdata (s_rdata)
   );

   arp_div #(.DW(DW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = {2'b00, ovel_ff, opitch_ff};
   assign rsp_tuser  = okind_ff;
   assign rsp_tlast  = olast_ff;

endmodule

// ===== hdl/arp_chk.sv =====
// ----------------------------------------------------------------------------
// arp_chk
// Port-level checks on the arpeggiator event stream.
// ----------------------------------------------------------------------------
module arp_chk (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);
   import arp_pkg::*;

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("event valid after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled event changed");

   a_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == EV_ON) |-> rsp_tlast)
      else $error("note on not final");

   a_off_vel: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == EV_OFF) |-> (rsp_tdata[13:7] == 7'd0))
      else $error("note off with velocity");

endmodule

bind note_arpeggiator arp_chk u_arp_chk (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
